// ===== rtl/core/cfhm_pkg.sv =====
// shared types, constants and helper functions of the component fault health monitor
`default_nettype none

package cfhm_pkg;

  // table size default and field widths
  localparam int unsigned NumComponentsDef = 64;
  localparam int unsigned CntW             = 32;
  localparam int unsigned RunW             = 8;
  localparam int unsigned AvgW             = 48;
  localparam int unsigned RtW              = 32;
  localparam int unsigned FracW            = 16;

  // divide-by-ten unit: 9*avg + (rt << 16) + 5 stays below 2^52
  localparam int unsigned DivW             = 52;
  localparam logic [3:0]  Divisor          = 4'd10;
  localparam logic [3:0]  DivRound         = 4'd5;

  // register reset values and run limits
  localparam logic [3:0]      MaxRetriesRst   = 4'd3;
  localparam logic            AutoRecoverRst  = 1'b1;
  localparam logic [RunW-1:0] UnhealthyRun    = 8'd5;
  localparam logic [RunW-1:0] HealthyRunLimit = 8'd3;

  typedef enum logic [0:0] {
    CfgMaxRetries  = 1'b0,
    CfgAutoRecover = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    KindCorruption = 4'd0,
    KindTimeout    = 4'd1,
    KindOverflow   = 4'd2,
    KindUnderflow  = 4'd3,
    KindMemory     = 4'd4,
    KindNetwork    = 4'd5,
    KindGpu        = 4'd6,
    KindDeadlock   = 4'd7,
    KindStarvation = 4'd8,
    KindOther      = 4'd9
  } fault_kind_e;

  typedef enum logic [1:0] {
    SevInfo     = 2'd0,
    SevWarning  = 2'd1,
    SevError    = 2'd2,
    SevCritical = 2'd3
  } severity_e;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActRetry    = 3'd1,
    ActFallback = 3'd2,
    ActReset    = 3'd3,
    ActEscalate = 3'd4
  } action_e;

  // one health table entry
  typedef struct packed {
    logic [CntW-1:0] ops;
    logic [CntW-1:0] succ;
    logic [RunW-1:0] run;
    logic [AvgW-1:0] avg;
    logic [RtW-1:0]  peak;
    logic            degraded;
    logic            healthy;
  } entry_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == '1) ? v : v + CntW'(1);
  endfunction

  function automatic logic [RunW-1:0] run_inc(input logic [RunW-1:0] v);
    return (v == '1) ? v : v + RunW'(1);
  endfunction

  function automatic severity_e kind_severity(input logic [3:0] kind);
    severity_e sev;
    unique case (kind) inside
      KindCorruption, KindDeadlock:         sev = SevCritical;
      KindTimeout, KindOverflow, KindGpu:   sev = SevError;
      KindUnderflow, KindMemory:            sev = SevWarning;
      default:                              sev = SevInfo;
    endcase
    return sev;
  endfunction

  function automatic action_e pick_action(input logic [3:0] kind, input logic [3:0] retries);
    action_e act;
    unique case (kind) inside
      KindCorruption, KindDeadlock:         act = ActReset;
      KindTimeout:                          act = (retries != '0) ? ActRetry : ActFallback;
      KindOverflow, KindUnderflow, KindGpu: act = ActFallback;
      KindMemory, KindNetwork:              act = ActRetry;
      KindStarvation:                       act = ActEscalate;
      default:                              act = ActNone;
    endcase
    return act;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/component_fault_health_monitor.sv =====
// top level of the component fault health monitor: sequencer, update logic and counters
//
// usage
// - input channel (in_valid_i / in_ready_o): one event per transfer, either an operation
//   outcome (func 0) or a fault report (func 1) for one component
// - output channel (out_valid_o / out_ready_i): exactly one result transfer per event,
//   in event order
// - config port: cfg_we_i writes max_retries (index 0) or auto_recover (index 1); write
//   only while no event is in flight
// - per event: the table entry is read at the input transfer, updated and written back
//   before the next event is taken, so one event is in work at a time
// - the result register loads in SFin, after SCalc has taken the read entry, and the next input
//   transfer can follow once the sequencer is back in SIdle; an outcome for a
//   component whose moving average is already nonzero also passes SDiv, where it waits
//   for the divide-by-ten series to finish
// - a result waits in the output register while the receiver stalls; the event after
//   it is accepted and worked on, then holds before write-back until the register frees
// - reset: all table entries read as zero (valid bit per entry), global counters clear,
//   max_retries returns to 3 and auto_recover to 1; no clearing pass is needed
`default_nettype none

module component_fault_health_monitor #(
  parameter int unsigned NUM_COMPONENTS = cfhm_pkg::NumComponentsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [3:0]  cfg_wdata_i,
  // event input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [7:0]  component_i,
  input  wire logic        success_i,
  input  wire logic [31:0] response_time_i,
  input  wire logic [3:0]  fault_kind_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      fault_number_o,
  output logic [1:0]       severity_o,
  output logic [2:0]       action_o,
  output logic             recovered_o,
  output logic             healthy_o,
  output logic             degraded_o,
  output logic [7:0]       failure_run_o,
  output logic [47:0]      avg_response_o,
  output logic [31:0]      peak_response_o,
  output logic [31:0]      open_faults_o
);
  import cfhm_pkg::*;

  localparam int unsigned IdxW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  typedef enum logic [1:0] {
    SIdle,
    SCalc,
    SDiv,
    SFin
  } state_e;

  state_e state_q;

  // configuration registers
  logic [3:0] max_retries_q;
  logic       auto_recover_q;

  // captured event
  logic            func_q;
  logic            comp_ok_q;
  logic [IdxW-1:0] addr_q;
  logic            ok_q;
  logic [RtW-1:0]  rt_q;
  logic [3:0]      kind_q;

  // working entry and per-event results
  entry_t          wk_q;
  logic [CntW-1:0] res_fnum_q;
  severity_e       res_sev_q;
  action_e         res_act_q;
  logic            res_rec_q;

  // global counters
  logic [CntW-1:0] fault_total_q;
  logic [CntW-1:0] recovered_total_q;
  logic [CntW-1:0] open_total_q;
  logic [CntW-1:0] unrecovered_total_q;

  // output register
  logic            out_valid_q;
  logic [CntW-1:0] out_fnum_q;
  severity_e       out_sev_q;
  action_e         out_act_q;
  logic            out_rec_q;
  logic            out_healthy_q;
  logic            out_degraded_q;
  logic [RunW-1:0] out_run_q;
  logic [AvgW-1:0] out_avg_q;
  logic [RtW-1:0]  out_peak_q;
  logic [CntW-1:0] out_open_q;

  // table and divider hookup
  logic            in_xfer;
  logic            in_comp_ok;
  logic            tbl_rd_en;
  entry_t          tbl_rd;
  logic            tbl_we;
  entry_t          fin_entry;
  logic            div_start;
  logic            div_busy;
  logic            div_done;
  logic [AvgW-1:0] div_quot;
  logic            out_free;

  // update terms
  entry_t          calc_entry;
  logic            calc_div;
  logic [DivW-1:0] calc_dividend;
  action_e         calc_act;
  logic            calc_good;
  logic [CntW-1:0] open_inc;
  logic [RunW-1:0] fault_run;
  logic [36:0]     succ_x20;
  logic [36:0]     ops_x19;
  logic [35:0]     succ_x10;
  logic [35:0]     ops_x7;

  assign in_ready_o = (state_q == SIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign in_comp_ok = {1'b0, component_i} < 9'(NUM_COMPONENTS);
  assign tbl_rd_en  = in_xfer && in_comp_ok;
  assign out_free   = !out_valid_q || out_ready_i;
  assign tbl_we     = (state_q == SFin) && out_free && comp_ok_q;
  assign div_start  = (state_q == SCalc) && calc_div;

  cfhm_table #(
    .NUM_COMPONENTS (NUM_COMPONENTS)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (component_i[IdxW-1:0]),
    .rd_data_o (tbl_rd),
    .wr_en_i   (tbl_we),
    .wr_addr_i (addr_q),
    .wr_data_i (fin_entry)
  );

  cfhm_div10 u_div10 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (calc_dividend),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // entry update while the read data is fresh
  always_comb begin
    calc_entry    = tbl_rd;
    calc_div      = 1'b0;
    // 9*avg + new sample in Q.16 + rounding
    calc_dividend = (DivW'(tbl_rd.avg) << 3) + DivW'(tbl_rd.avg)
                  + DivW'({rt_q, {FracW{1'b0}}}) + DivW'(DivRound);
    calc_act      = auto_recover_q ? pick_action(kind_q, max_retries_q) : ActNone;
    case (calc_act)
      ActRetry:    calc_good = (max_retries_q != '0);
      ActFallback: calc_good = 1'b1;
      ActReset:    calc_good = comp_ok_q;
      default:     calc_good = 1'b0;
    endcase
    open_inc  = sat_inc(open_total_q);
    fault_run = run_inc(tbl_rd.run);

    if (!func_q) begin
      // operation outcome; flags are settled at write-back
      calc_entry.ops = sat_inc(tbl_rd.ops);
      if (ok_q) begin
        calc_entry.succ = sat_inc(tbl_rd.succ);
        calc_entry.run  = '0;
      end else begin
        calc_entry.run  = fault_run;
      end
      if (tbl_rd.avg == '0) begin
        calc_entry.avg = {rt_q, {FracW{1'b0}}};
      end else begin
        calc_div = 1'b1;
      end
      if (rt_q > tbl_rd.peak) begin
        calc_entry.peak = rt_q;
      end
    end else begin
      // fault report
      calc_entry.run = fault_run;
      if (fault_run >= UnhealthyRun) begin
        calc_entry.healthy  = 1'b0;
        calc_entry.degraded = 1'b1;
      end
      if (calc_act == ActReset && comp_ok_q) begin
        calc_entry.run      = '0;
        calc_entry.healthy  = 1'b1;
        calc_entry.degraded = 1'b0;
      end
    end
  end

  // success ratio checks by cross-multiplication against 0.95 and 0.7
  always_comb begin
    succ_x20 = 37'({wk_q.succ, 4'b0}) + 37'({wk_q.succ, 2'b0});
    ops_x19  = 37'({wk_q.ops, 4'b0}) + 37'({wk_q.ops, 1'b0}) + 37'(wk_q.ops);
    succ_x10 = 36'({wk_q.succ, 3'b0}) + 36'({wk_q.succ, 1'b0});
    ops_x7   = 36'({wk_q.ops, 2'b0}) + 36'({wk_q.ops, 1'b0}) + 36'(wk_q.ops);
    fin_entry = wk_q;
    if (!func_q) begin
      fin_entry.healthy  = (succ_x20 > ops_x19) && (wk_q.run < HealthyRunLimit);
      fin_entry.degraded = (succ_x20 < ops_x19) && (succ_x10 > ops_x7);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q  <= MaxRetriesRst;
      auto_recover_q <= AutoRecoverRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgMaxRetries:  max_retries_q  <= cfg_wdata_i;
        CfgAutoRecover: auto_recover_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // event sequencer with working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= SIdle;
      func_q              <= 1'b0;
      comp_ok_q           <= 1'b0;
      addr_q              <= '0;
      ok_q                <= 1'b0;
      rt_q                <= '0;
      kind_q              <= '0;
      wk_q                <= '0;
      res_fnum_q          <= '0;
      res_sev_q           <= SevInfo;
      res_act_q           <= ActNone;
      res_rec_q           <= 1'b0;
      fault_total_q       <= '0;
      recovered_total_q   <= '0;
      open_total_q        <= '0;
      unrecovered_total_q <= '0;
      out_valid_q         <= 1'b0;
      out_fnum_q          <= '0;
      out_sev_q           <= SevInfo;
      out_act_q           <= ActNone;
      out_rec_q           <= 1'b0;
      out_healthy_q       <= 1'b0;
      out_degraded_q      <= 1'b0;
      out_run_q           <= '0;
      out_avg_q           <= '0;
      out_peak_q          <= '0;
      out_open_q          <= '0;
    end else begin
      // the final state reloads the register itself
      if (out_ready_i && (state_q != SFin)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            func_q    <= func_i;
            comp_ok_q <= in_comp_ok;
            addr_q    <= component_i[IdxW-1:0];
            ok_q      <= success_i;
            rt_q      <= response_time_i;
            kind_q    <= fault_kind_i;
            state_q   <= SCalc;
          end
        end
        SCalc: begin
          wk_q       <= calc_entry;
          res_fnum_q <= func_q ? fault_total_q : '0;
          res_sev_q  <= func_q ? kind_severity(kind_q) : SevInfo;
          res_act_q  <= func_q ? calc_act : ActNone;
          res_rec_q  <= func_q && (calc_act != ActNone) && calc_good;
          if (func_q) begin
            fault_total_q <= sat_inc(fault_total_q);
            open_total_q  <= ((calc_act != ActNone) && calc_good) ? open_inc - CntW'(1)
                                                                  : open_inc;
            if (calc_act != ActNone) begin
              if (calc_good) begin
                recovered_total_q <= sat_inc(recovered_total_q);
              end else begin
                unrecovered_total_q <= sat_inc(unrecovered_total_q);
              end
            end
          end
          state_q <= calc_div ? SDiv : SFin;
        end
        SDiv: begin
          if (div_done) begin
            wk_q.avg <= div_quot;
            state_q  <= SFin;
          end
        end
        SFin: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_fnum_q     <= res_fnum_q;
            out_sev_q      <= res_sev_q;
            out_act_q      <= res_act_q;
            out_rec_q      <= res_rec_q;
            out_healthy_q  <= comp_ok_q && fin_entry.healthy;
            out_degraded_q <= comp_ok_q && fin_entry.degraded;
            out_run_q      <= comp_ok_q ? fin_entry.run : '0;
            out_avg_q      <= comp_ok_q ? fin_entry.avg : '0;
            out_peak_q     <= comp_ok_q ? fin_entry.peak : '0;
            out_open_q     <= open_total_q;
            state_q        <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fault_number_o  = out_fnum_q;
  assign severity_o      = out_sev_q;
  assign action_o        = out_act_q;
  assign recovered_o     = out_rec_q;
  assign healthy_o       = out_healthy_q;
  assign degraded_o      = out_degraded_q;
  assign failure_run_o   = out_run_q;
  assign avg_response_o  = out_avg_q;
  assign peak_response_o = out_peak_q;
  assign open_faults_o   = out_open_q;

`ifndef NO_ASSERTIONS
  // table is only written for components inside the table
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> comp_ok_q)
    else $error("table write for out-of-range component");

  // a new event is never taken while the divider still runs
  a_no_accept_during_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("input ready while divider busy");

  // open faults can never exceed reported faults
  a_open_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_total_q <= fault_total_q)
    else $error("open fault count above fault total");

  // a recovered result always carries an action
  a_rec_has_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && recovered_o) |-> (action_o != ActNone))
    else $error("recovered without recovery action");

  // an outcome written back always has a nonzero operation count
  a_outcome_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_we && !func_q) |-> (fin_entry.ops != '0))
    else $error("outcome write-back with zero operation count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cfhm_table.sv =====
// health table memory with registered read and per-entry valid bits
`default_nettype none

module cfhm_table #(
  parameter int unsigned NUM_COMPONENTS = cfhm_pkg::NumComponentsDef,
  localparam int unsigned IdxW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IdxW-1:0]  rd_addr_i,
  output cfhm_pkg::entry_t      rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [IdxW-1:0]  wr_addr_i,
  input  cfhm_pkg::entry_t      wr_data_i
);
  import cfhm_pkg::*;

  entry_t                    mem_q [NUM_COMPONENTS];
  entry_t                    rdata_q;
  logic [NUM_COMPONENTS-1:0] vld_q;
  logic                      rd_vld_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/cfhm_div10.sv =====
// divide-by-ten unit: shift-and-add reciprocal series with one remainder correction
`default_nettype none

module cfhm_div10 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cfhm_pkg::DivW-1:0]  dividend_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [cfhm_pkg::AvgW-1:0]       quotient_o
);
  import cfhm_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StPrep,
    StFold4,
    StFold8,
    StFold16,
    StFold32,
    StScale,
    StFix
  } step_e;

  step_e           step_q;
  logic [DivW-1:0] num_q;
  logic [DivW-1:0] acc_q;
  logic [AvgW-1:0] quot_q;
  logic            done_q;
  logic [4:0]      rem_low;

  // estimate is at most one low, so the remainder is below 20 and five bits hold it
  assign rem_low = 5'(num_q[4:0] - ({quot_q[1:0], 3'b000} + {quot_q[3:0], 1'b0}));

  // x * 3/4 * (1 + 2^-4)(1 + 2^-8)(1 + 2^-16)(1 + 2^-32) / 8 approximates x / 10
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StIdle;
      num_q  <= '0;
      acc_q  <= '0;
      quot_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == StFix);
      if (start_i) begin
        num_q  <= dividend_i;
        step_q <= StPrep;
      end else begin
        unique case (step_q)
          StIdle: ;
          StPrep: begin
            acc_q  <= (num_q >> 1) + (num_q >> 2);
            step_q <= StFold4;
          end
          StFold4: begin
            acc_q  <= acc_q + (acc_q >> 4);
            step_q <= StFold8;
          end
          StFold8: begin
            acc_q  <= acc_q + (acc_q >> 8);
            step_q <= StFold16;
          end
          StFold16: begin
            acc_q  <= acc_q + (acc_q >> 16);
            step_q <= StFold32;
          end
          StFold32: begin
            acc_q  <= acc_q + (acc_q >> 32);
            step_q <= StScale;
          end
          StScale: begin
            quot_q <= acc_q[AvgW+2:3];
            step_q <= StFix;
          end
          StFix: begin
            if (rem_low >= 5'(Divisor)) begin
              quot_q <= quot_q + AvgW'(1);
            end
            step_q <= StIdle;
          end
          default: step_q <= StIdle;
        endcase
      end
    end
  end

  assign busy_o     = (step_q != StIdle);
  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

`default_nettype wire
